// ===== rtl/pdh_pkg.sv =====
// Shared types, constants and helpers of the pair distance histogram.
package pdh_pkg;

   localparam int NUM_BINS = 256;
   localparam int NUM_TYPES = 4;
   localparam int STORE_DEPTH = NUM_TYPES * NUM_TYPES * NUM_BINS;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [30:0] SAT_MAG = '1;

   localparam logic [1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] CSR_BOX_X = 3'd0;
   localparam logic [2:0] CSR_BOX_Y = 3'd1;
   localparam logic [2:0] CSR_BOX_Z = 3'd2;
   localparam logic [2:0] CSR_INV_X = 3'd3;
   localparam logic [2:0] CSR_INV_Y = 3'd4;
   localparam logic [2:0] CSR_INV_Z = 3'd5;
   localparam logic [2:0] CSR_INV_BIN = 3'd6;
   localparam logic [2:0] CSR_SAME_MOL = 3'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic [1:0] type_a;
      logic [1:0] type_b;
      logic [15:0] molecule_a;
      logic [15:0] molecule_b;
      logic [7:0] read_bin;
   } req_type;

   typedef struct packed {
      logic [31:0] bin_count;
      logic counted;
      logic [7:0] bin_hit;
   } rsp_type;

   typedef struct packed {
      logic [2:0][30:0] box_len;
      logic [2:0][31:0] inv_box;
      logic [31:0] inv_bin_width;
      logic count_same_molecule;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_COUNT,
      CMD_READ,
      CMD_ZERO,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0] bin_hit;
   } cmd_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [1:0] ta, input logic [1:0] tb,
                                                 input logic [BIN_W-1:0] bin);
      return ADDR_W'((int'(ta) * NUM_TYPES + int'(tb)) * NUM_BINS + int'(bin));
   endfunction

endpackage

// ===== rtl/pdh_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/pdh_queue.sv =====
// Short command queue between the front end and the histogram back end.
module pdh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pdh_pkg::cmd_type push_cmd,
   input  logic             pop,
   output pdh_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import pdh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head = entries_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/pdh_front.sv =====
// Front end: classifies transactions and computes the minimum-image distance bin.
module pdh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  pdh_pkg::req_type req,
   input  pdh_pkg::cfg_type cfg,
   input  logic             queue_full,
   output logic             push,
   output pdh_pkg::cmd_type push_cmd,
   output logic             front_busy
);
   import pdh_pkg::*;

   localparam logic [1:0] MUL_LAST = 2'd2;
   localparam logic [1:0] AXIS_LAST = 2'd2;
   localparam logic [4:0] SQRT_LAST = 5'd31;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_SQRT, S_PUSH} state_type;
   typedef enum logic [1:0] {P_NINT, P_FOLD, P_SQUARE, P_BIN} phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] axis_ff, axis_in, chunk_ff, chunk_in, ta_ff, ta_in, tb_ff, tb_in;
   logic [65:0] acc_ff, acc_in;
   logic [47:0] mul_a_ff, mul_a_in;
   logic [31:0] mul_b_ff, mul_b_in;
   logic [32:0] mag_ff [3];
   logic [32:0] mag_in [3];
   logic [63:0] rad_ff, rad_in;
   logic [31:0] root_ff, root_in;
   logic [33:0] rem_ff, rem_in;
   logic [4:0] step_ff, step_in;
   cmd_type cmd_ff, cmd_in;

   logic [47:0] pp;
   logic [65:0] prod, rounded;
   logic signed [49:0] rem_s;
   logic [49:0] rem_mag;
   logic [30:0] fold_r;
   logic [35:0] remt, trial;
   logic [32:0] d_x, d_y, d_z;
   logic [31:0] bin;
   logic types_ok, read_ok;

   assign pp = mul_a_ff[16*chunk_ff +: 16] * mul_b_ff;
   assign prod = acc_ff + (66'(pp) << (16 * chunk_ff));
   assign rounded = prod + (66'(1) << 47);
   assign rem_s = $signed({17'b0, mag_ff[axis_ff]}) - $signed({1'b0, prod[48:0]});
   assign rem_mag = rem_s[49] ? 50'(-rem_s) : 50'(rem_s);
   assign fold_r = (rem_mag > 50'(SAT_MAG)) ? SAT_MAG : rem_mag[30:0];
   assign remt = {rem_ff, rad_ff[63:62]};
   assign trial = {2'b0, root_ff, 2'b01};
   assign bin = prod[63:32];
   assign d_x = {req.pos_a_x[31], req.pos_a_x} - {req.pos_b_x[31], req.pos_b_x};
   assign d_y = {req.pos_a_y[31], req.pos_a_y} - {req.pos_b_y[31], req.pos_b_y};
   assign d_z = {req.pos_a_z[31], req.pos_a_z} - {req.pos_b_z[31], req.pos_b_z};
   assign types_ok = (int'(req.type_a) < NUM_TYPES) && (int'(req.type_b) < NUM_TYPES);
   assign read_ok = types_ok && (int'(req.read_bin) < NUM_BINS);
   assign front_busy = (state_ff != S_IDLE) || queue_full;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in = axis_ff;
      chunk_in = chunk_ff;
      ta_in = ta_ff;
      tb_in = tb_ff;
      acc_in = acc_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      mag_in = mag_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      cmd_in = cmd_ff;
      push = 1'b0;
      push_cmd = cmd_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ta_in = req.type_a;
               tb_in = req.type_b;
               mag_in[0] = d_x[32] ? 33'(-d_x) : d_x;
               mag_in[1] = d_y[32] ? 33'(-d_y) : d_y;
               mag_in[2] = d_z[32] ? 33'(-d_z) : d_z;
               case (req.operation)
                  OP_ACCUMULATE: begin
                     if (!types_ok ||
                         (!cfg.count_same_molecule && req.molecule_a == req.molecule_b)) begin
                        push = 1'b1;
                        push_cmd = '{kind: CMD_ZERO, addr: '0, bin_hit: '0};
                     end else begin
                        state_in = S_MUL;
                        phase_in = P_NINT;
                        axis_in = '0;
                        chunk_in = '0;
                        acc_in = '0;
                        rad_in = '0;
                        mul_a_in = 48'(mag_in[0]);
                        mul_b_in = cfg.inv_box[0];
                     end
                  end
                  OP_READ: begin
                     push = 1'b1;
                     if (read_ok) begin
                        push_cmd = '{kind: CMD_READ,
                                     addr: addr_of(req.type_a, req.type_b,
                                                   BIN_W'(req.read_bin)),
                                     bin_hit: req.read_bin};
                     end else begin
                        push_cmd = '{kind: CMD_ZERO, addr: '0, bin_hit: req.read_bin};
                     end
                  end
                  OP_CLEAR: begin
                     push = 1'b1;
                     push_cmd = '{kind: CMD_CLEAR, addr: '0, bin_hit: '0};
                  end
                  default: begin
                     push = 1'b1;
                     push_cmd = '{kind: CMD_ZERO, addr: '0, bin_hit: '0};
                  end
               endcase
            end
         end
         S_MUL: begin
            if (chunk_ff != MUL_LAST) begin
               chunk_in = chunk_ff + 1'b1;
               acc_in = prod;
            end else begin
               chunk_in = '0;
               acc_in = '0;
               case (phase_ff)
                  P_NINT: begin
                     mul_a_in = 48'(rounded[65:48]);
                     mul_b_in = {1'b0, cfg.box_len[axis_ff]};
                     phase_in = P_FOLD;
                  end
                  P_FOLD: begin
                     mul_a_in = 48'(fold_r);
                     mul_b_in = {1'b0, fold_r};
                     phase_in = P_SQUARE;
                  end
                  P_SQUARE: begin
                     rad_in = rad_ff + 64'(prod[61:0]);
                     if (axis_ff == AXIS_LAST) begin
                        state_in = S_SQRT;
                        root_in = '0;
                        rem_in = '0;
                        step_in = '0;
                     end else begin
                        axis_in = axis_ff + 1'b1;
                        mul_a_in = 48'(mag_ff[axis_ff + 1'b1]);
                        mul_b_in = cfg.inv_box[axis_ff + 1'b1];
                        phase_in = P_NINT;
                     end
                  end
                  P_BIN: begin
                     state_in = S_PUSH;
                     if (33'(bin) < 33'(NUM_BINS)) begin
                        cmd_in = '{kind: CMD_COUNT,
                                   addr: addr_of(ta_ff, tb_ff, bin[BIN_W-1:0]),
                                   bin_hit: bin[7:0]};
                     end else begin
                        cmd_in = '{kind: CMD_ZERO, addr: '0, bin_hit: '0};
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SQRT: begin
            rad_in = rad_ff << 2;
            step_in = step_ff + 1'b1;
            if (remt >= trial) begin
               rem_in = 34'(remt - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = 34'(remt);
               root_in = {root_ff[30:0], 1'b0};
            end
            if (step_ff == SQRT_LAST) begin
               state_in = S_MUL;
               phase_in = P_BIN;
               chunk_in = '0;
               acc_in = '0;
               mul_a_in = 48'(root_in);
               mul_b_in = cfg.inv_bin_width;
            end
         end
         S_PUSH: begin
            if (!queue_full) begin
               push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      axis_ff <= axis_in;
      chunk_ff <= chunk_in;
      ta_ff <= ta_in;
      tb_ff <= tb_in;
      acc_ff <= acc_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mag_ff <= mag_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      cmd_ff <= cmd_in;
   end

endmodule

// ===== rtl/pdh_back.sv =====
// Back end: histogram store read-modify-write, reads, clearing sweeps and results.
module pdh_back (
   input  logic             clock,
   input  logic             reset,
   input  pdh_pkg::cmd_type head,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   output pdh_pkg::rsp_type rsp,
   output logic             init_busy
);
   import pdh_pkg::*;

   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);

   typedef enum logic [1:0] {B_IDLE, B_READ, B_SWEEP} state_type;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic init_ff, init_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [31:0] ram_wdata, ram_rdata, bumped;

   pdh_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign bumped = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign init_busy = init_ff;
   assign ram_raddr = head.addr;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      sweep_in = sweep_ff;
      init_in = init_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = cmd_ff.addr;
      ram_wdata = bumped;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               cmd_in = head;
               case (head.kind)
                  CMD_COUNT, CMD_READ: begin
                     state_in = B_READ;
                  end
                  CMD_CLEAR: begin
                     state_in = B_SWEEP;
                     sweep_in = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{bin_count: '0, counted: 1'b0, bin_hit: head.bin_hit};
                  end
               endcase
            end
         end
         B_READ: begin
            state_in = B_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff.kind == CMD_COUNT) begin
               ram_we = 1'b1;
               rsp_in = '{bin_count: bumped, counted: 1'b1, bin_hit: cmd_ff.bin_hit};
            end else begin
               rsp_in = '{bin_count: ram_rdata, counted: 1'b0, bin_hit: cmd_ff.bin_hit};
            end
         end
         B_SWEEP: begin
            ram_we = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               state_in = B_IDLE;
               init_in = 1'b0;
               if (!init_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_SWEEP;
         sweep_ff <= '0;
         init_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         init_ff <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/pair_distance_histogram.sv =====
// Top level of the pair distance histogram: configuration, front end, queue and back end.
// After reset the block clears its 4096-entry store in one sweep with busy high.
// An accumulate transaction occupies the front end while nine multiplies on one shared
// 16x32 multiplier fold and square the three axes, a 32-step square root follows and
// one more multiply gives the bin. Reads, clears and skipped pairs are pushed to the
// queue straight from idle. The back end pops a command and updates or reads in its
// read state or zeroes the store in a sweep. Each result appears on rsp for one cycle
// with rsp_valid high; it cannot be held off, so the receiver must take it in that cycle.
module pair_distance_histogram (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pdh_pkg::req_type req,
   output logic             rsp_valid,
   output pdh_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import pdh_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic accept, front_busy, init_busy, push, pop, queue_empty, queue_full;
   cmd_type push_cmd, head;

   assign accept = start && !busy;
   assign busy = front_busy || init_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BOX_X: cfg_in.box_len[0] = csr_wdata[30:0];
            CSR_BOX_Y: cfg_in.box_len[1] = csr_wdata[30:0];
            CSR_BOX_Z: cfg_in.box_len[2] = csr_wdata[30:0];
            CSR_INV_X: cfg_in.inv_box[0] = csr_wdata;
            CSR_INV_Y: cfg_in.inv_box[1] = csr_wdata;
            CSR_INV_Z: cfg_in.inv_box[2] = csr_wdata;
            CSR_INV_BIN: cfg_in.inv_bin_width = csr_wdata;
            CSR_SAME_MOL: cfg_in.count_same_molecule = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_len <= {3{31'd655360}};
         cfg_ff.inv_box <= {3{32'd429496730}};
         cfg_ff.inv_bin_width <= 32'd3355443;
         cfg_ff.count_same_molecule <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdh_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req),
      .cfg(cfg_ff),
      .queue_full(queue_full),
      .push(push),
      .push_cmd(push_cmd),
      .front_busy(front_busy)
   );

   pdh_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .head(head),
      .empty(queue_empty),
      .full(queue_full)
   );

   pdh_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .queue_empty(queue_empty),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp(rsp),
      .init_busy(init_busy)
   );

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.counted |-> rsp.bin_count != '0)
      else $error("counted result with a zero counter");

   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full || pop)
      else $error("push into a full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_empty)
      else $error("pop from an empty queue");

endmodule
